FILE: hw/rtl/twlr_pkg.sv
// Shared types, constants and tables of the tilt water LED ring block.
`timescale 1ns / 1ps
package twlr_pkg;

  localparam int LED_COUNT = 35;
  localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam int INV_GAIN  = 39797;
  localparam int TWO_PI    = 411775;
  localparam int BASE_GLOW = 26214;
  localparam int STR_DIV   = 1000;
  // ceil(2^31 / 125): floor(m * 256 / 1000) = (m * STR_RECIP) >> 26 for m < 2^18
  localparam int STR_RECIP = 17179870;
  localparam int CORD_LAST = 15;
  localparam int DIV_FULL  = 33;
  localparam int DIV_FRAC  = 16;

  localparam logic [13:0] ARC_TAB [16] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
  };

  typedef logic [15:0] pos_tab_t [LED_COUNT];

  function automatic pos_tab_t build_pos();
    pos_tab_t tab;
    for (int i = 0; i < LED_COUNT; i++) begin
      tab[i] = 16'((i * 65536) / LED_COUNT);
    end
    return tab;
  endfunction

  localparam pos_tab_t POS_TAB = build_pos();

  typedef enum logic [2:0] {
    REG_SPRING = 3'd0,
    REG_DAMP   = 3'd1,
    REG_VLIM   = 3'd2,
    REG_FILL   = 3'd3,
    REG_SBASE  = 3'd4,
    REG_SSCALE = 3'd5,
    REG_OFFSET = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CORD_STEP, OP_VEC_END, OP_MUL_M, OP_MUL_STR, OP_DIV_STEP,
    OP_STR, OP_MUL_DG, OP_MUL_PS, OP_PUSH, OP_MUL_DMP, OP_CLAMP, OP_MUL_Z1,
    OP_MUL_Z2, OP_ZONE, OP_MUL_GL, OP_GLOW, OP_ROT_LD, OP_ROT_END, OP_DQ_LD,
    OP_Q_END, OP_T_END, OP_MUL_TT, OP_MUL_TG, OP_LVL, OP_MUL_GC, OP_G_END,
    OP_MUL_BC, OP_B_END, OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_VEC, S_VEC_END, S_MUL_M, S_MUL_STR, S_STR, S_MUL_DG,
    S_MUL_PS, S_PUSH, S_MUL_DMP, S_CLAMP, S_MUL_Z1, S_MUL_Z2, S_ZONE, S_MUL_GL,
    S_GLOW, S_ROT_LD, S_ROT, S_ROT_END, S_DQ_LD, S_DQ, S_Q_END, S_DT, S_T_END,
    S_MUL_TT, S_MUL_TG, S_LVL, S_MUL_GC, S_G_END, S_MUL_BC, S_B_END, S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic cord_last;
    logic div_last;
    logic under;
    logic splash;
    logic led_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/twlr_in_if.sv
// Input sample channel: valid/ready with the two acceleration fields.
`timescale 1ns / 1ps
interface twlr_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] accel_x;
  logic signed [14:0] accel_y;
  modport source (output valid, output accel_x, output accel_y, input ready);
  modport sink (input valid, input accel_x, input accel_y, output ready);
endinterface

FILE: hw/rtl/twlr_out_if.sv
// Result channel: one LED colour per beat.
`timescale 1ns / 1ps
interface twlr_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] led_index;
  logic [6:0] green_level;
  logic [7:0] blue_level;
  logic       last_led;
  modport source (output valid, output led_index, output green_level,
                  output blue_level, output last_led, input ready);
  modport sink (input valid, input led_index, input green_level,
                input blue_level, input last_led, output ready);
endinterface

FILE: hw/rtl/twlr_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface twlr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/tilt_water_led_ring_core.sv
// Top level of the tilt water LED ring: sequencer plus datapath.
`timescale 1ns / 1ps
//
//  channel   dir  beat payload                                  handshake
//  in_bus    in   accel_x, accel_y (15 b signed, milli-g)       valid/ready
//  out_bus   out  led_index, green_level, blue_level, last_led  valid/ready
//  cfg_bus   in   index (3 b), data (16 b)                      valid/ready
//
//  One sample runs the physics pass, then renders each of the 35 LEDs in turn;
//  the 33-step bit-serial divider and the 16-step CORDIC run for every LED, an
//  underwater LED adds the colour products and a splash LED adds a 16-step
//  divide ahead of them.
//  Synchronous active-low reset returns the config registers to defaults
//  and water to rest; no clearing pass is needed. A stalled out_bus holds its
//  beat while the next LED is computed, then the sequencer waits for the slot.
//  in_bus is ready only between samples; cfg_bus is always ready.
//
module tilt_water_led_ring_core (
  input  logic       clk,
  input  logic       rst_n,
  twlr_in_if.sink    in_bus,
  twlr_out_if.source out_bus,
  twlr_cfg_if.sink   cfg_bus
);
  import twlr_pkg::*;

  cmd_t cmd;
  sts_t dp_sts, sts;

  // ready comes from the sequencer: high only while it waits for a sample
  assign in_bus.ready = cmd.in_ready;

  // merge the input valid into the status bundle seen by the sequencer
  always_comb begin
    sts          = dp_sts;
    sts.in_valid = in_bus.valid;
  end

  twlr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  twlr_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (dp_sts),
    .in_x    (in_bus.accel_x),
    .in_y    (in_bus.accel_y),
    .cfg_bus (cfg_bus),
    .out_bus (out_bus)
  );

endmodule

FILE: hw/rtl/twlr_ctrl.sv
// Sequencer that steps the datapath through physics and per-LED render.
`timescale 1ns / 1ps
module twlr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  twlr_pkg::sts_t sts,
  output twlr_pkg::cmd_t cmd
);
  import twlr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_VEC;
        end
      end
      S_VEC: begin
        cmd.op = OP_CORD_STEP;
        if (sts.cord_last) state_nxt = S_VEC_END;
      end
      S_VEC_END: begin cmd.op = OP_VEC_END; state_nxt = S_MUL_M; end
      S_MUL_M:   begin cmd.op = OP_MUL_M; state_nxt = S_MUL_STR; end
      S_MUL_STR: begin cmd.op = OP_MUL_STR; state_nxt = S_STR; end
      S_STR:     begin cmd.op = OP_STR; state_nxt = S_MUL_DG; end
      S_MUL_DG:  begin cmd.op = OP_MUL_DG; state_nxt = S_MUL_PS; end
      S_MUL_PS:  begin cmd.op = OP_MUL_PS; state_nxt = S_PUSH; end
      S_PUSH:    begin cmd.op = OP_PUSH; state_nxt = S_MUL_DMP; end
      S_MUL_DMP: begin cmd.op = OP_MUL_DMP; state_nxt = S_CLAMP; end
      S_CLAMP:   begin cmd.op = OP_CLAMP; state_nxt = S_MUL_Z1; end
      S_MUL_Z1:  begin cmd.op = OP_MUL_Z1; state_nxt = S_MUL_Z2; end
      S_MUL_Z2:  begin cmd.op = OP_MUL_Z2; state_nxt = S_ZONE; end
      S_ZONE:    begin cmd.op = OP_ZONE; state_nxt = S_MUL_GL; end
      S_MUL_GL:  begin cmd.op = OP_MUL_GL; state_nxt = S_GLOW; end
      S_GLOW:    begin cmd.op = OP_GLOW; state_nxt = S_ROT_LD; end
      S_ROT_LD:  begin cmd.op = OP_ROT_LD; state_nxt = S_ROT; end
      S_ROT: begin
        cmd.op = OP_CORD_STEP;
        if (sts.cord_last) state_nxt = S_ROT_END;
      end
      S_ROT_END: begin cmd.op = OP_ROT_END; state_nxt = S_DQ_LD; end
      S_DQ_LD:   begin cmd.op = OP_DQ_LD; state_nxt = S_DQ; end
      S_DQ: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) state_nxt = S_Q_END;
      end
      S_Q_END: begin
        cmd.op = OP_Q_END;
        priority if (sts.under) state_nxt = S_MUL_GC;
        else if (sts.splash) state_nxt = S_DT;
        else state_nxt = S_OUT;
      end
      S_DT: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) state_nxt = S_T_END;
      end
      S_T_END:   begin cmd.op = OP_T_END; state_nxt = S_MUL_TT; end
      S_MUL_TT:  begin cmd.op = OP_MUL_TT; state_nxt = S_MUL_TG; end
      S_MUL_TG:  begin cmd.op = OP_MUL_TG; state_nxt = S_LVL; end
      S_LVL:     begin cmd.op = OP_LVL; state_nxt = S_MUL_GC; end
      S_MUL_GC:  begin cmd.op = OP_MUL_GC; state_nxt = S_G_END; end
      S_G_END:   begin cmd.op = OP_G_END; state_nxt = S_MUL_BC; end
      S_MUL_BC:  begin cmd.op = OP_MUL_BC; state_nxt = S_B_END; end
      S_B_END:   begin cmd.op = OP_B_END; state_nxt = S_OUT; end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = sts.led_last ? S_IDLE : S_ROT_LD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/twlr_dp.sv
// Datapath: config registers, shared CORDIC, divider, multiplier, output stage.
`timescale 1ns / 1ps
module twlr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  twlr_pkg::cmd_t     cmd,
  output twlr_pkg::sts_t     sts,
  input  logic signed [14:0] in_x,
  input  logic signed [14:0] in_y,
  twlr_cfg_if.sink           cfg_bus,
  twlr_out_if.source         out_bus
);
  import twlr_pkg::*;

  // configuration
  logic [15:0] gain_r, damp_r, fill_r, base_r, ss_r, offs_r;
  logic [14:0] lim_r;

  // state carried between samples
  logic [15:0]        surf_r;
  logic signed [15:0] spd_r;

  // CORDIC
  logic signed [25:0] ca_r, cb_r, ca_nxt, cb_nxt, da, db;
  logic [17:0]        cz_r, cz_nxt, arc;
  logic [3:0]         ck_r;
  logic               cmode_r, flip_r, zero_r, up;

  // divider
  logic [32:0] dvd_r;
  logic [26:0] rem_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic [27:0] trial;
  logic        ge;

  // multiplier
  logic [31:0] mul_a;
  logic [20:0] mul_b;
  logic [52:0] mul_p_r;

  // physics and render values
  logic [15:0]        dif_mag_r;
  logic               dif_neg_r;
  logic [24:0]        len_r;
  logic               str_big_r;
  logic [16:0]        str_r, tf_r, glow_r, p_r;
  logic signed [17:0] vel_r, thr_r, c_r;
  logic [14:0]        v_r;
  logic [26:0]        zone_r;
  logic               under_r;
  logic [LED_W-1:0]   led_r;
  logic [6:0]         g_r;
  logic [7:0]         b_r;

  // output stage
  logic       out_v_r;
  logic [6:0] oidx_r, og_r;
  logic [7:0] ob_r;
  logic       olast_r;

  // combinational helpers
  logic signed [25:0] xa, ya;
  logic [15:0]        dirv, diffw, rel;
  logic [16:0]        pm, vmag, cmag;
  logic signed [17:0] vsum, srel, sadj, velc;
  logic [14:0]        mag15;
  logic signed [25:0] af;
  logic signed [18:0] dq;
  logic [20:0]        gsum;
  logic               led_last, splash;

  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid       = out_v_r;
  assign out_bus.led_index   = oidx_r;
  assign out_bus.green_level = og_r;
  assign out_bus.blue_level  = ob_r;
  assign out_bus.last_led    = olast_r;

  assign led_last = (led_r == LED_W'(LED_COUNT - 1));
  assign splash   = (zone_r != '0) && (dvd_r < {6'd0, zone_r});

  assign sts.in_valid  = 1'b0;
  assign sts.cord_last = (ck_r == 4'(CORD_LAST));
  assign sts.div_last  = (dcnt_r == 6'd1);
  assign sts.under     = under_r;
  assign sts.splash    = splash;
  assign sts.led_last  = led_last;
  assign sts.out_free  = !out_v_r || out_bus.ready;

  // one CORDIC micro-rotation
  always_comb begin
    da  = cb_r >>> ck_r;
    db  = ca_r >>> ck_r;
    arc = {4'd0, ARC_TAB[ck_r]};
    up  = cmode_r ? (cb_r > 26'sd0) : cz_r[17];
    if (up) begin
      ca_nxt = ca_r + da;
      cb_nxt = cb_r - db;
      cz_nxt = cz_r + arc;
    end else begin
      ca_nxt = ca_r - da;
      cb_nxt = cb_r + db;
      cz_nxt = cz_r - arc;
    end
  end

  // one restoring division step
  always_comb begin
    trial = {rem_r, dvd_r[32]};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_comb begin
    xa    = {{3{in_x[14]}}, in_x, 8'd0};
    ya    = {{3{in_y[14]}}, in_y, 8'd0};
    dirv  = zero_r ? 16'd0 : cz_r[15:0];
    diffw = dirv - surf_r;
    pm    = 17'((mul_p_r[48:0] + 49'h0_8000_0000) >> 32);
    vsum  = 18'(spd_r) + (dif_neg_r ? -$signed({1'b0, pm}) : $signed({1'b0, pm}));
    vmag  = vel_r[17] ? 17'(-vel_r) : vel_r[16:0];
    mag15 = (mul_p_r[32:16] > {2'd0, lim_r}) ? lim_r : mul_p_r[30:16];
    velc  = vel_r[17] ? -$signed({3'd0, mag15}) : $signed({3'd0, mag15});
    rel   = POS_TAB[led_r] + offs_r - surf_r;
    srel  = 18'($signed(rel));
    if (srel > 18'sd16384) sadj = srel - 18'sd32768;
    else if (srel < -18'sd16384) sadj = srel + 18'sd32768;
    else sadj = srel;
    af    = flip_r ? -ca_r : ca_r;
    dq    = (c_r >= thr_r) ? 19'(c_r) - 19'(thr_r) : 19'(thr_r) - 19'(c_r);
    cmag  = dq[16:0];
    gsum  = 21'(BASE_GLOW) + mul_p_r[35:16];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_M:   begin mul_a = {7'd0, len_r};       mul_b = 21'(INV_GAIN); end
      OP_MUL_STR: begin mul_a = 32'(STR_RECIP);      mul_b = {3'd0, mul_p_r[33:16]}; end
      OP_MUL_DG:  begin mul_a = {16'd0, dif_mag_r};  mul_b = {5'd0, gain_r}; end
      OP_MUL_PS:  begin mul_a = mul_p_r[31:0];       mul_b = {4'd0, str_r}; end
      OP_MUL_DMP: begin mul_a = {15'd0, vmag};       mul_b = {5'd0, damp_r}; end
      OP_MUL_Z1:  begin mul_a = {17'd0, v_r};        mul_b = {5'd0, ss_r}; end
      OP_MUL_Z2:  begin mul_a = {1'b0, mul_p_r[30:0]}; mul_b = 21'(TWO_PI); end
      OP_MUL_GL:  begin mul_a = {17'd0, v_r};        mul_b = 21'(5 * TWO_PI); end
      OP_MUL_TT:  begin mul_a = {15'd0, p_r};        mul_b = {4'd0, p_r}; end
      OP_MUL_TG:  begin mul_a = {15'd0, mul_p_r[32:16]}; mul_b = {4'd0, glow_r}; end
      OP_MUL_GC:  begin mul_a = {15'd0, p_r}; mul_b = under_r ? 21'd80 : 21'd120; end
      OP_MUL_BC:  begin mul_a = {15'd0, p_r}; mul_b = under_r ? 21'd200 : 21'd220; end
      default: ;
    endcase
  end

  // config registers, carried state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= 16'd786;
      damp_r  <= 16'd62915;
      lim_r   <= 15'd1564;
      fill_r  <= 16'd29491;
      base_r  <= 16'd7864;
      ss_r    <= 16'd2048;
      offs_r  <= 16'd0;
      surf_r  <= 16'd0;
      spd_r   <= 16'sd0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        unique case (cfg_bus.index)
          REG_SPRING: gain_r <= cfg_bus.data;
          REG_DAMP:   damp_r <= cfg_bus.data;
          REG_VLIM:   lim_r  <= cfg_bus.data[14:0];
          REG_FILL:   fill_r <= cfg_bus.data;
          REG_SBASE:  base_r <= cfg_bus.data;
          REG_SSCALE: ss_r   <= cfg_bus.data;
          REG_OFFSET: offs_r <= cfg_bus.data;
          default: ;
        endcase
      end
      if (cmd.op == OP_CLAMP) begin
        spd_r  <= velc[15:0];
        surf_r <= surf_r + 16'(velc);
      end
      if (cmd.op == OP_OUT) out_v_r <= 1'b1;
      else if (out_bus.ready) out_v_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_MUL_M, OP_MUL_STR, OP_MUL_DG, OP_MUL_PS, OP_MUL_DMP, OP_MUL_Z1, OP_MUL_Z2,
      OP_MUL_GL, OP_MUL_TT, OP_MUL_TG, OP_MUL_GC, OP_MUL_BC:
        mul_p_r <= 53'(mul_a) * 53'(mul_b);
      default: ;
    endcase
    unique case (cmd.op)
      OP_LOAD: begin
        cmode_r <= 1'b1;
        ck_r    <= 4'd0;
        zero_r  <= (in_x == 15'sd0) && (in_y == 15'sd0);
        if (in_x < 15'sd0) begin
          ca_r <= -xa;
          cb_r <= -ya;
          cz_r <= 18'd32768;
        end else begin
          ca_r <= xa;
          cb_r <= ya;
          cz_r <= 18'd0;
        end
      end
      OP_CORD_STEP: begin
        ca_r <= ca_nxt;
        cb_r <= cb_nxt;
        cz_r <= cz_nxt;
        ck_r <= ck_r + 4'd1;
      end
      OP_VEC_END: begin
        len_r     <= zero_r ? 25'd0 : ca_r[24:0];
        dif_neg_r <= diffw[15];
        dif_mag_r <= diffw[15] ? -diffw : diffw;
      end
      // a magnitude of 2^18 or more always saturates the strength
      OP_MUL_STR: str_big_r <= (mul_p_r[39:34] != 6'd0);
      OP_DIV_STEP: begin
        rem_r  <= ge ? 27'(trial - {1'b0, dvs_r}) : trial[26:0];
        dvd_r  <= {dvd_r[31:0], ge};
        dcnt_r <= dcnt_r - 6'd1;
      end
      OP_STR: begin
        str_r <= (str_big_r || (mul_p_r[42:26] > 17'd65536)) ? 17'd65536 : mul_p_r[42:26];
      end
      OP_PUSH: vel_r <= vsum;
      OP_CLAMP: begin
        v_r   <= mag15;
        tf_r  <= {(fill_r == 16'd0) ? 16'd1 : fill_r, 1'b0};
        thr_r <= 18'sd65536 - $signed({1'b0, (fill_r == 16'd0) ? 16'd1 : fill_r, 1'b0});
      end
      OP_ZONE: zone_r <= {11'd0, base_r} + {1'b0, mul_p_r[49:24]};
      OP_GLOW: begin
        glow_r <= (gsum > 21'd65536) ? 17'd65536 : gsum[16:0];
        led_r  <= '0;
      end
      OP_ROT_LD: begin
        cmode_r <= 1'b0;
        ck_r    <= 4'd0;
        flip_r  <= (srel > 18'sd16384) || (srel < -18'sd16384);
        ca_r    <= 26'(INV_GAIN);
        cb_r    <= '0;
        cz_r    <= sadj;
      end
      OP_ROT_END: begin
        priority if (af > 26'sd65536) c_r <= 18'sd65536;
        else if (af < -26'sd65536) c_r <= -18'sd65536;
        else c_r <= af[17:0];
      end
      OP_DQ_LD: begin
        under_r <= c_r >= thr_r;
        dvd_r   <= {cmag, 16'd0};
        dvs_r   <= {10'd0, tf_r};
        rem_r   <= '0;
        dcnt_r  <= 6'(DIV_FULL);
      end
      OP_Q_END: begin
        priority if (under_r) begin
          p_r <= (dvd_r >= 33'd65536) ? 17'd0 : 17'd65536 - dvd_r[16:0];
        end else if (splash) begin
          rem_r  <= dvd_r[26:0];
          dvd_r  <= '0;
          dvs_r  <= zone_r;
          dcnt_r <= 6'(DIV_FRAC);
        end else begin
          g_r <= '0;
          b_r <= '0;
        end
      end
      OP_T_END: p_r <= 17'd65536 - dvd_r[16:0];
      OP_LVL:   p_r <= mul_p_r[32:16];
      OP_G_END: g_r <= mul_p_r[22:16];
      OP_B_END: b_r <= mul_p_r[23:16] + (under_r ? 8'd30 : 8'd0);
      OP_OUT: begin
        oidx_r  <= 7'(led_r) + 7'd1;
        og_r    <= g_r;
        ob_r    <= b_r;
        olast_r <= led_last;
        if (!led_last) led_r <= led_r + LED_W'(1);
      end
      default: ;
    endcase
  end

endmodule
